// File: rtl/core/bsl_pkg.sv
// Shared types and constants for the bounded sequential list.
// Holds the beat structs, opcode codes and storage sizes; no dependencies.
`timescale 1ns / 1ps

package bsl_pkg;

    localparam int MAX_ELEMENTS = 256;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int POS_W        = 9;
    localparam int CAP_W        = 9;
    localparam int OUT_CNT_W    = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_AT    = 3'd1,
        OP_APPEND    = 3'd2,
        OP_REM_FRONT = 3'd3,
        OP_REM_AT    = 3'd4,
        OP_REM_LAST  = 3'd5,
        OP_SEARCH    = 3'd6,
        OP_COUNT_ODD = 3'd7
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [DATA_W-1:0] item_value;
        logic [POS_W-1:0]         position;
    } req_t;

    typedef struct packed {
        logic                     success;
        logic signed [DATA_W-1:0] removed_value;
        logic [OUT_CNT_W-1:0]     odd_count;
        logic [OUT_CNT_W-1:0]     list_length;
    } rsp_t;

    // Engine status toward the handshake logic
    typedef struct packed {
        logic idle;
        logic done;
    } eng_status_t;

endpackage

// File: rtl/core/bounded_sequential_list.sv
// Top level of the bounded sequential list: handshakes, capacity register, result register.
// Depends on bsl_pkg and bsl_engine.
//
//   channel   dir  handshake              beat
//   s_        in   s_valid / s_ready      bsl_pkg::req_t  (opcode, item_value, position)
//   m_        out  m_valid / m_ready      bsl_pkg::rsp_t  (success, removed_value, ...)
//   cfg_      in   cfg_valid / cfg_ready  capacity_in_use, 9 bits
//
// One request at a time; s_ready is low from accept until the engine hands off its result.
// Inserts and removes shift the entries past the position one place at a time, and search
// and count odd scan the list from the front through the store; remove last and rejected
// requests go straight to the result.
// The result register lets a new request enter while the previous result waits on m_ready.
// aresetn (synchronous) empties the list and sets capacity to 256; store content is not cleared.
`timescale 1ns / 1ps

module bounded_sequential_list (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  bsl_pkg::req_t              s_payload,
    output logic                       m_valid,
    input  logic                       m_ready,
    output bsl_pkg::rsp_t              m_payload,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bsl_pkg::CAP_W-1:0]  cfg_data
);
    import bsl_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic             m_valid_reg;
    rsp_t             m_payload_reg;
    eng_status_t      eng_status;
    rsp_t             eng_rsp;
    logic             start;
    logic             take;

    assign cfg_ready = 1'b1;
    assign s_ready   = eng_status.idle;
    assign start     = s_valid && s_ready;
    // Advance a finished result into the output register once it is free
    assign take      = eng_status.done && (!m_valid_reg || m_ready);

    bsl_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .req      (s_payload),
        .capacity (cap_reg),
        .take     (take),
        .status   (eng_status),
        .rsp      (eng_rsp)
    );

    // Capacity register and output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            if (take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (take) begin
            m_payload_reg <= eng_rsp;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.list_length <= OUT_CNT_W'(MAX_ELEMENTS)))
        else $error("list length beyond store size");

    a_odd_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.odd_count <= m_payload.list_length))
        else $error("odd count exceeds list length");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while engine busy");

    a_done_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(eng_status.idle && eng_status.done))
        else $error("engine idle and done together");
`endif

endmodule

// File: rtl/core/bsl_engine.sv
// List engine: element store plus the sequencer that shifts, scans and counts.
// Depends on bsl_pkg for the request/response beats and size constants.
`timescale 1ns / 1ps

module bsl_engine (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  bsl_pkg::req_t           req,
    input  logic [bsl_pkg::CAP_W-1:0] capacity,
    input  logic                    take,
    output bsl_pkg::eng_status_t    status,
    output bsl_pkg::rsp_t           rsp
);
    import bsl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SHIFT,
        ST_INS_PUT,
        ST_REM_HEAD,
        ST_REM_SHIFT,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Element store, one write and one registered read per cycle
    logic [DATA_W-1:0] mem [MAX_ELEMENTS];
    logic [DATA_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic                ok_reg, ok_next;
    logic [DATA_W-1:0]   removed_reg, removed_next;
    logic [CNT_W-1:0]    odd_reg, odd_next;

    logic [CNT_W-1:0]    limit;
    logic                full, empty;
    logic                pos_ins_ok, pos_rem_ok;
    logic [IDX_W-1:0]    pos_idx;
    logic [IDX_W-1:0]    ins_idx;
    logic [CNT_W:0]      cnt_plus1;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Request checks against the current count and capacity
    always_comb begin
        limit      = (capacity > CAP_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                       : CNT_W'(capacity);
        full       = count_reg >= limit;
        empty      = count_reg == '0;
        cnt_plus1  = (CNT_W+1)'(count_reg) + (CNT_W+1)'(1);
        pos_ins_ok = (req.position != '0) && ((CNT_W+1)'(req.position) <= cnt_plus1);
        pos_rem_ok = (req.position != '0) && ((CNT_W+1)'(req.position) <=
                                              (CNT_W+1)'(count_reg));
        pos_idx    = IDX_W'(req.position - POS_W'(1));
        unique case (op_t'(req.opcode))
            OP_INS_FRONT: ins_idx = '0;
            OP_INS_AT:    ins_idx = pos_idx;
            default:      ins_idx = IDX_W'(count_reg);
        endcase
    end

    // Sequencer: shifts, scans and counts through the element store
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        idx_next     = idx_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        ok_next      = ok_reg;
        removed_next = removed_reg;
        odd_next     = odd_reg;
        rd_addr      = ptr_reg;
        wr_en        = 1'b0;
        wr_addr      = ptr_reg;
        wr_data      = rd_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    op_next      = req.opcode;
                    val_next     = req.item_value;
                    ok_next      = 1'b0;
                    removed_next = '0;
                    odd_next     = '0;
                    state_next   = ST_DONE;
                    unique case (op_t'(req.opcode))
                        OP_INS_FRONT, OP_INS_AT, OP_APPEND: begin
                            if (!full && (op_t'(req.opcode) != OP_INS_AT || pos_ins_ok)) begin
                                idx_next = ins_idx;
                                if (CNT_W'(ins_idx) == count_reg) begin
                                    state_next = ST_INS_PUT;
                                end else begin
                                    rd_addr    = IDX_W'(count_reg - CNT_W'(1));
                                    ptr_next   = IDX_W'(count_reg);
                                    state_next = ST_INS_SHIFT;
                                end
                            end
                        end
                        OP_REM_FRONT, OP_REM_AT: begin
                            if (!empty && (op_t'(req.opcode) != OP_REM_AT || pos_rem_ok)) begin
                                rd_addr    = (op_t'(req.opcode) == OP_REM_AT) ? pos_idx : '0;
                                ptr_next   = rd_addr;
                                state_next = ST_REM_HEAD;
                            end
                        end
                        OP_REM_LAST: begin
                            if (!empty) begin
                                ok_next    = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        default: begin
                            // search and count odd scan from the front
                            ok_next = (op_t'(req.opcode) == OP_COUNT_ODD) && empty;
                            if (!empty) begin
                                rd_addr    = '0;
                                ptr_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                    endcase
                end
            end
            ST_INS_SHIFT: begin
                // move the entry below the pointer one place up
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_data = rd_data_reg;
                if (ptr_reg - IDX_W'(1) == idx_reg) begin
                    state_next = ST_INS_PUT;
                end else begin
                    rd_addr  = ptr_reg - IDX_W'(2);
                    ptr_next = ptr_reg - IDX_W'(1);
                end
            end
            ST_INS_PUT: begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = val_reg;
                ok_next    = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_DONE;
            end
            ST_REM_HEAD: begin
                // keep the removed word for remove front only
                if (op_t'(op_reg) == OP_REM_FRONT) begin
                    removed_next = rd_data_reg;
                end
                if (CNT_W'(ptr_reg) + CNT_W'(1) < count_reg) begin
                    rd_addr    = ptr_reg + IDX_W'(1);
                    state_next = ST_REM_SHIFT;
                end else begin
                    ok_next    = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end
            ST_REM_SHIFT: begin
                // move the next entry one place down
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_data = rd_data_reg;
                if (CNT_W'(ptr_reg) + CNT_W'(2) < count_reg) begin
                    rd_addr  = ptr_reg + IDX_W'(2);
                    ptr_next = ptr_reg + IDX_W'(1);
                end else begin
                    ok_next    = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (op_t'(op_reg) == OP_SEARCH && rd_data_reg == val_reg) begin
                    ok_next    = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    if (op_t'(op_reg) == OP_COUNT_ODD) begin
                        odd_next = odd_reg + CNT_W'(rd_data_reg[0]);
                    end
                    if (CNT_W'(ptr_reg) + CNT_W'(1) < count_reg) begin
                        rd_addr  = ptr_reg + IDX_W'(1);
                        ptr_next = ptr_reg + IDX_W'(1);
                    end else begin
                        ok_next    = op_t'(op_reg) == OP_COUNT_ODD;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        ptr_reg     <= ptr_next;
        idx_reg     <= idx_next;
        op_reg      <= op_next;
        val_reg     <= val_next;
        ok_reg      <= ok_next;
        removed_reg <= removed_next;
        odd_reg     <= odd_next;
    end

    assign status.idle = state_reg == ST_IDLE;
    assign status.done = state_reg == ST_DONE;

    assign rsp.success       = ok_reg;
    assign rsp.removed_value = removed_reg;
    assign rsp.odd_count     = OUT_CNT_W'(odd_reg);
    assign rsp.list_length   = OUT_CNT_W'(count_reg);

endmodule

// File: bench/tb.sv
// Self-checking bench for bounded_sequential_list: drives request beats, checks every result.
// Keeps its own list model in a queue; depends on bsl_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;
    import bsl_pkg::*;

    localparam int CYCLE_LIMIT    = 2000000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 150;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid   = 1'b0;
    logic              s_ready;
    req_t              s_payload = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    rsp_t              m_payload;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CAP_W-1:0]  cfg_data  = '0;

    // request paired with the result the list model predicts for it
    typedef struct packed {
        req_t req;
        rsp_t rsp;
    } predicted_t;

    req_t       req_pend_q[$];
    predicted_t predicted_rsp_q[$];

    // list model: contents, capacity register, run statistics
    logic signed [DATA_W-1:0] shadow_list[$];
    int unsigned              cap_reg = 256;
    int                       n_ok;
    int                       n_rejected;
    int                       longest_list;

    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    bit  rx_hold_go   = 1'b0;
    int  rx_hold_cnt  = 0;
    bit  in_taken     = 1'b0;
    int  n_queued     = 0;
    int  n_checked    = 0;
    int  err_count    = 0;
    int  cycle_count  = 0;

    predicted_t want;

    bounded_sequential_list DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d results pending",
                     cycle_count, predicted_rsp_q.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Apply one request to the list model and return the result it yields.
    function automatic rsp_t list_apply(req_t r);
        rsp_t        rsp;
        int          n;
        int          lim;
        int          pos;
        int          odd;
        bit          full;
        bit          empty;
        rsp   = '0;
        odd   = 0;
        n     = shadow_list.size();
        lim   = (cap_reg > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(cap_reg);
        pos   = int'(r.position);
        full  = n >= lim;
        empty = n == 0;
        case (op_t'(r.opcode))
            OP_INS_FRONT: if (!full) begin
                shadow_list.push_front(r.item_value);
                rsp.success = 1'b1;
            end
            OP_INS_AT: if (!full && pos >= 1 && pos <= n + 1) begin
                shadow_list.insert(pos - 1, r.item_value);
                rsp.success = 1'b1;
            end
            OP_APPEND: if (!full) begin
                shadow_list.push_back(r.item_value);
                rsp.success = 1'b1;
            end
            OP_REM_FRONT: if (!empty) begin
                rsp.removed_value = shadow_list.pop_front();
                rsp.success = 1'b1;
            end
            OP_REM_AT: if (!empty && pos >= 1 && pos <= n) begin
                shadow_list.delete(pos - 1);
                rsp.success = 1'b1;
            end
            OP_REM_LAST: if (!empty) begin
                void'(shadow_list.pop_back());
                rsp.success = 1'b1;
            end
            OP_SEARCH: begin
                foreach (shadow_list[i])
                    if (shadow_list[i] == r.item_value) rsp.success = 1'b1;
            end
            default: begin
                foreach (shadow_list[i]) odd += shadow_list[i][0];
                rsp.odd_count = OUT_CNT_W'(odd);
                rsp.success = 1'b1;
            end
        endcase
        rsp.list_length = OUT_CNT_W'(shadow_list.size());
        if (rsp.success) n_ok++;
        else n_rejected++;
        if (shadow_list.size() > longest_list) longest_list = shadow_list.size();
        return rsp;
    endfunction

    // Monitor: check the result beat first (it is older), then predict the new request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_rsp_q.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing expected (len %0d)",
                                              m_payload.list_length));
                end else begin
                    want = predicted_rsp_q.pop_front();
                    n_checked++;
                    if (m_payload.success !== want.rsp.success)
                        report_mismatch($sformatf("op %0d pos %0d: success %0b, expected %0b",
                            want.req.opcode, want.req.position,
                            m_payload.success, want.rsp.success));
                    if (m_payload.removed_value !== want.rsp.removed_value)
                        report_mismatch($sformatf("op %0d: removed_value %0d, expected %0d",
                            want.req.opcode, m_payload.removed_value,
                            want.rsp.removed_value));
                    if (m_payload.odd_count !== want.rsp.odd_count)
                        report_mismatch($sformatf("op %0d: odd_count %0d, expected %0d",
                            want.req.opcode, m_payload.odd_count, want.rsp.odd_count));
                    if (m_payload.list_length !== want.rsp.list_length)
                        report_mismatch($sformatf("op %0d pos %0d: list_length %0d, expected %0d",
                            want.req.opcode, want.req.position,
                            m_payload.list_length, want.rsp.list_length));
                end
            end
            in_taken = s_valid && s_ready;
            if (in_taken)
                predicted_rsp_q.push_back({s_payload, list_apply(s_payload)});
        end
    end

    // Driver: hold the beat until taken, then offer the next one or idle.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (req_pend_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_payload <= req_pend_q.pop_front();
                s_valid   <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    always @(negedge aclk) begin
        if (rx_hold_go && rx_hold_cnt < RX_HOLD_CYCLES) begin
            m_ready     <= 1'b0;
            rx_hold_cnt <= rx_hold_cnt + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic queue_req(input op_t op, input logic signed [DATA_W-1:0] value,
                             input int pos);
        req_t r;
        r.opcode     = op;
        r.item_value = value;
        r.position   = POS_W'(pos);
        req_pend_q.push_back(r);
        n_queued++;
    endtask

    // Build one random request; ins_pct biases the list toward growing.
    function automatic req_t make_request(int ins_pct);
        req_t r;
        int   span;
        int   pick;
        span = (cap_reg > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(cap_reg);
        pick = $urandom_range(99);
        if ($urandom_range(99) < 3) begin
            r.opcode     = OP_W'($urandom_range(7));
            r.item_value = $urandom;
            r.position   = POS_W'($urandom_range(511));
            return r;
        end
        if (pick < ins_pct) begin
            case ($urandom_range(2))
                0:       r.opcode = OP_INS_FRONT;
                1:       r.opcode = OP_INS_AT;
                default: r.opcode = OP_APPEND;
            endcase
        end else if (pick < ins_pct + (100 - ins_pct) * 7 / 10) begin
            case ($urandom_range(2))
                0:       r.opcode = OP_REM_FRONT;
                1:       r.opcode = OP_REM_AT;
                default: r.opcode = OP_REM_LAST;
            endcase
        end else begin
            r.opcode = ($urandom_range(1) == 0) ? OP_SEARCH : OP_COUNT_ODD;
        end
        if ($urandom_range(9) == 0) r.position = POS_W'($urandom_range(511));
        else r.position = POS_W'($urandom_range(span + 1, 1));
        // small pool so searches hit; extremes now and then
        case ($urandom_range(9))
            0: case ($urandom_range(3))
                   0:       r.item_value = 32'sh8000_0000;
                   1:       r.item_value = 32'sh7FFF_FFFF;
                   2:       r.item_value = 32'sh0;
                   default: r.item_value = -32'sd1;
               endcase
            1, 2, 3, 4: r.item_value = int'($urandom_range(7)) - 4;
            default:    r.item_value = $urandom;
        endcase
        return r;
    endfunction

    // Pause the sender until every predicted result has arrived.
    task automatic drain();
        do @(negedge aclk); while (n_checked != n_queued);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_capacity(input int cap);
        @(negedge aclk);
        cfg_data  = CAP_W'(cap);
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cap_reg = cap;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_phase(input int cap, input int n_items, input int ins_pct,
                             input int tx_pct, input int rx_pct);
        drain();
        write_capacity(cap);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (n_items) begin
            req_pend_q.push_back(make_request(ins_pct));
            n_queued++;
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty list, bad positions, extreme values, capacity at reset
        queue_req(OP_COUNT_ODD, 0, 0);
        queue_req(OP_REM_FRONT, 0, 0);
        queue_req(OP_REM_AT, 0, 1);
        queue_req(OP_REM_LAST, 0, 0);
        queue_req(OP_SEARCH, 0, 0);
        queue_req(OP_INS_AT, 5, 0);
        queue_req(OP_INS_AT, 5, 2);
        queue_req(OP_INS_AT, 32'sh7FFF_FFFF, 1);
        queue_req(OP_INS_FRONT, 32'sh8000_0000, 0);
        queue_req(OP_APPEND, -32'sd1, 0);
        queue_req(OP_APPEND, 0, 0);
        queue_req(OP_INS_AT, 3, 5);
        queue_req(OP_INS_AT, 9, 511);
        queue_req(OP_SEARCH, 32'sh8000_0000, 0);
        queue_req(OP_SEARCH, 12345, 0);
        queue_req(OP_COUNT_ODD, 0, 0);
        queue_req(OP_REM_AT, 0, 0);
        queue_req(OP_REM_AT, 0, 6);
        queue_req(OP_REM_AT, 0, 256);
        queue_req(OP_REM_AT, 0, 3);
        queue_req(OP_REM_FRONT, 0, 0);
        queue_req(OP_REM_LAST, 0, 0);
        queue_req(OP_REM_AT, 0, 1);
        queue_req(OP_REM_FRONT, 0, 0);
        queue_req(OP_REM_FRONT, 0, 0);

        // zero capacity: always full
        run_phase(0, 40, 60, 0, 0);
        run_phase(1, 80, 50, 62, 0);
        run_phase(5, 130, 55, 0, 62);
        // long receiver hold-off while the sender keeps offering
        run_phase(16, 180, 70, 22, 22);
        rx_hold_go = 1'b1;
        // capacity dropped below the current count
        run_phase(4, 120, 50, 0, 0);
        // capacity above the store saturates; fill the store to the top
        run_phase(300, 340, 97, 62, 0);
        run_phase(511, 100, 20, 0, 62);
        run_phase(40, 100, 55, 22, 22);
        run_phase(256, 50, 50, 0, 0);

        drain();
        repeat (MAX_ELEMENTS + 8) @(negedge aclk);
        if (predicted_rsp_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", predicted_rsp_q.size()));

        $display("tb: %0d requests checked (%0d succeeded, %0d rejected), longest list %0d",
                 n_checked, n_ok, n_rejected, longest_list);
        $display("tb: capacities 0 to 511 incl. below count, idle/stall phases, long hold-off");
        if (err_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
